FILE: hw/rtl/scmix_pkg.sv
// ----------------------------------------------------------------------------
// scmix_pkg
// Types, widths and constants shared by the soft-clip mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scmix_pkg;

  localparam int NUM_SOURCES = 4;
  localparam int FULL_SCALE  = 32768;
  localparam int SAMPLE_W    = 16;
  localparam int QBITS       = 30;
  localparam int Q1_W        = QBITS + 1;
  localparam int FS_LOG2     = $clog2(FULL_SCALE);
  localparam int SUM_W       = SAMPLE_W + $clog2(NUM_SOURCES);
  localparam int MAG_W       = SUM_W;
  localparam int Y_W         = MAG_W + 1 + QBITS - FS_LOG2;
  localparam int NFULL_W     = Y_W - QBITS;
  localparam int MAG_MAX     = NUM_SOURCES * (1 << (SAMPLE_W - 1));
  localparam int N_STEPS_RAW = (MAG_MAX * 2) / FULL_SCALE;
  localparam int N_STEPS     = (N_STEPS_RAW > 31) ? 31 : N_STEPS_RAW;
  localparam int N_W         = $clog2(N_STEPS + 1);
  localparam int TERMS       = 20;
  localparam int MAGIC_W     = 31;
  localparam int OUT_MAG_W   = SAMPLE_W - 1;
  localparam int LIMIT       = (FULL_SCALE - 1 > 32767) ? 32767 : FULL_SCALE - 1;

  localparam logic [Q1_W-1:0] QONE = {1'b1, {QBITS{1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic signed [SAMPLE_W-1:0] sample_c;
    logic signed [SAMPLE_W-1:0] sample_d;
    logic [NUM_SOURCES-1:0]     source_valid;
    logic                       frame_end;
  } scmix_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       frame_end_out;
  } scmix_out_t;

  // sideband that rides along the datapath with each transaction
  typedef struct packed {
    logic           neg;
    logic           sat;
    logic           frame_end;
    logic [N_W-1:0] n;
  } scmix_side_t;

  // e^-1 in Q30, same truncated series as the datapath
  function automatic logic [Q1_W-1:0] exp_neg_one_q30();
    longint      sum;
    logic [63:0] term;
    int          k;
    sum  = longint'(1) << QBITS;
    term = 64'd1 << QBITS;
    for (k = 1; k <= TERMS; k++) begin
      term = ((term * (64'd1 << QBITS)) >> QBITS) / 64'(k);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << QBITS)) begin
      sum = longint'(1) << QBITS;
    end
    return Q1_W'(sum);
  endfunction

  localparam logic [Q1_W-1:0] E1_Q30 = exp_neg_one_q30();

endpackage

`default_nettype wire

FILE: hw/rtl/scmix_exp.sv
// ----------------------------------------------------------------------------
// scmix_exp
// Pipelined e^-g in Q30: truncated Taylor series, two stages per term
// (term times g, then exact divide by k through a reciprocal multiply),
// followed by a clamp stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scmix_exp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [scmix_pkg::QBITS-1:0] in_g,
  input  scmix_pkg::scmix_side_t      in_side,
  output logic                        out_valid,
  output logic [scmix_pkg::Q1_W-1:0]  out_e,
  output scmix_pkg::scmix_side_t      out_side
);
  import scmix_pkg::*;

  localparam int ACC_W = QBITS + 3;
  localparam int PA_W  = Q1_W + QBITS;
  localparam int PB_W  = QBITS + MAGIC_W;
  localparam logic signed [ACC_W-1:0] SUM_INIT = ACC_W'(QONE);

  logic                    a_v_r    [1:TERMS];
  logic [QBITS-1:0]        a_x_r    [1:TERMS];
  logic signed [ACC_W-1:0] a_sum_r  [1:TERMS];
  logic [QBITS-1:0]        a_g_r    [1:TERMS-1];
  scmix_side_t             a_side_r [1:TERMS];

  logic                    b_v_r    [1:TERMS];
  logic [Q1_W-1:0]         b_term_r [1:TERMS-1];
  logic signed [ACC_W-1:0] b_sum_r  [1:TERMS];
  logic [QBITS-1:0]        b_g_r    [1:TERMS-1];
  scmix_side_t             b_side_r [1:TERMS];

  logic                    e_v_r;
  logic [Q1_W-1:0]         e_r;
  scmix_side_t             e_side_r;
  logic [Q1_W-1:0]         e_nxt;

  genvar k;
  for (k = 1; k <= TERMS; k++) begin : g_term
    localparam int L = $clog2(k);
    localparam logic [MAGIC_W-1:0] MAGIC =
      MAGIC_W'(((64'd1 << (QBITS + L)) + 64'(k - 1)) / 64'(k));

    logic                    src_v;
    logic [Q1_W-1:0]         src_term;
    logic signed [ACC_W-1:0] src_sum;
    logic [QBITS-1:0]        src_g;
    scmix_side_t             src_side;
    logic [PA_W-1:0]         prod_a;
    logic [PB_W-1:0]         prod_b;
    logic [PB_W-1:0]         t_full;
    logic [QBITS-1:0]        t_k;
    logic signed [ACC_W-1:0] sum_nxt;

    if (k == 1) begin : g_src_in
      assign src_v    = in_valid;
      assign src_term = QONE;
      assign src_sum  = SUM_INIT;
      assign src_g    = in_g;
      assign src_side = in_side;
    end else begin : g_src_prev
      assign src_v    = b_v_r[k-1];
      assign src_term = b_term_r[k-1];
      assign src_sum  = b_sum_r[k-1];
      assign src_g    = b_g_r[k-1];
      assign src_side = b_side_r[k-1];
    end

    assign prod_a = PA_W'(src_term) * PA_W'(src_g);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r[k] <= 1'b0;
      end else if (en) begin
        a_v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_x_r[k]    <= prod_a[QBITS +: QBITS];
        a_sum_r[k]  <= src_sum;
        a_side_r[k] <= src_side;
      end
    end

    // exact floor divide by k
    assign prod_b = PB_W'(a_x_r[k]) * PB_W'(MAGIC);
    assign t_full = prod_b >> (QBITS + L);
    assign t_k    = t_full[QBITS-1:0];

    if (k % 2 == 1) begin : g_sub
      assign sum_nxt = a_sum_r[k] - $signed(ACC_W'(t_k));
    end else begin : g_add
      assign sum_nxt = a_sum_r[k] + $signed(ACC_W'(t_k));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r[k] <= 1'b0;
      end else if (en) begin
        b_v_r[k] <= a_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_sum_r[k]  <= sum_nxt;
        b_side_r[k] <= a_side_r[k];
      end
    end

    if (k < TERMS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          a_g_r[k]    <= src_g;
          b_term_r[k] <= {1'b0, t_k};
          b_g_r[k]    <= a_g_r[k];
        end
      end
    end
  end

  always_comb begin
    if (b_sum_r[TERMS][ACC_W-1]) begin
      e_nxt = '0;
    end else if (b_sum_r[TERMS] > SUM_INIT) begin
      e_nxt = QONE;
    end else begin
      e_nxt = b_sum_r[TERMS][Q1_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= b_v_r[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r      <= e_nxt;
      e_side_r <= b_side_r[TERMS];
    end
  end

  assign out_valid = e_v_r;
  assign out_e     = e_r;
  assign out_side  = e_side_r;

endmodule

`default_nettype wire

FILE: hw/rtl/scmix_pow.sv
// ----------------------------------------------------------------------------
// scmix_pow
// Scales e^-f by e^-1 once per integer unit of 2x, one conditional
// multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scmix_pow (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [scmix_pkg::Q1_W-1:0] in_u,
  input  scmix_pkg::scmix_side_t     in_side,
  output logic                       out_valid,
  output logic [scmix_pkg::Q1_W-1:0] out_u,
  output scmix_pkg::scmix_side_t     out_side
);
  import scmix_pkg::*;

  localparam int P_W = 2 * Q1_W;

  logic            v_r    [0:N_STEPS-1];
  logic [Q1_W-1:0] u_r    [0:N_STEPS-1];
  scmix_side_t     side_r [0:N_STEPS-1];

  genvar i;
  for (i = 0; i < N_STEPS; i++) begin : g_step
    localparam logic [N_W-1:0] IDX = N_W'(i);

    logic            src_v;
    logic [Q1_W-1:0] src_u;
    scmix_side_t     src_side;
    logic [P_W-1:0]  prod;
    logic [Q1_W-1:0] u_nxt;

    if (i == 0) begin : g_src_in
      assign src_v    = in_valid;
      assign src_u    = in_u;
      assign src_side = in_side;
    end else begin : g_src_prev
      assign src_v    = v_r[i-1];
      assign src_u    = u_r[i-1];
      assign src_side = side_r[i-1];
    end

    assign prod  = P_W'(src_u) * P_W'(E1_Q30);
    assign u_nxt = (src_side.n > IDX) ? prod[QBITS +: Q1_W] : src_u;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u_r[i]    <= u_nxt;
        side_r[i] <= src_side;
      end
    end
  end

  assign out_valid = v_r[N_STEPS-1];
  assign out_u     = u_r[N_STEPS-1];
  assign out_side  = side_r[N_STEPS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/scmix_div.sv
// ----------------------------------------------------------------------------
// scmix_div
// Pipelined restoring divider for tanh = (1 - u) / (1 + u) in Q30,
// two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scmix_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [scmix_pkg::Q1_W-1:0] in_u,
  input  scmix_pkg::scmix_side_t     in_side,
  output logic                       out_valid,
  output logic [scmix_pkg::Q1_W-1:0] out_t,
  output scmix_pkg::scmix_side_t     out_side
);
  import scmix_pkg::*;

  localparam int DIV_PER    = 2;
  localparam int QD_W       = ((Q1_W + DIV_PER - 1) / DIV_PER) * DIV_PER;
  localparam int DIV_STAGES = QD_W / DIV_PER;
  localparam int D_W        = Q1_W + 1;
  localparam int NUM_W      = Q1_W + QBITS;

  logic [Q1_W-1:0]  a_num;
  logic [D_W-1:0]   d_in;
  logic [NUM_W-1:0] num_in;

  logic             v_r    [0:DIV_STAGES-1];
  logic [QD_W-1:0]  q_r    [0:DIV_STAGES-1];
  scmix_side_t      side_r [0:DIV_STAGES-1];
  logic [D_W-1:0]   rem_r  [0:DIV_STAGES-2];
  logic [QD_W-1:0]  lo_r   [0:DIV_STAGES-2];
  logic [D_W-1:0]   d_r    [0:DIV_STAGES-2];

  assign a_num  = QONE - in_u;
  assign d_in   = D_W'(QONE) + D_W'(in_u);
  assign num_in = {a_num, {QBITS{1'b0}}};

  genvar s;
  for (s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic            src_v;
    logic [D_W-1:0]  src_rem;
    logic [QD_W-1:0] src_lo;
    logic [QD_W-1:0] src_q;
    logic [D_W-1:0]  src_d;
    scmix_side_t     src_side;
    logic [D_W-1:0]  rem_nxt;
    logic [QD_W-1:0] lo_nxt;
    logic [QD_W-1:0] q_nxt;
    logic [D_W:0]    sh;

    if (s == 0) begin : g_src_in
      assign src_v    = in_valid;
      assign src_rem  = D_W'(num_in >> QD_W);
      assign src_lo   = num_in[QD_W-1:0];
      assign src_q    = '0;
      assign src_d    = d_in;
      assign src_side = in_side;
    end else begin : g_src_prev
      assign src_v    = v_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_lo   = lo_r[s-1];
      assign src_q    = q_r[s-1];
      assign src_d    = d_r[s-1];
      assign src_side = side_r[s-1];
    end

    always_comb begin
      rem_nxt = src_rem;
      lo_nxt  = src_lo;
      q_nxt   = src_q;
      sh      = '0;
      for (int b = 0; b < DIV_PER; b++) begin
        sh     = {rem_nxt, lo_nxt[QD_W-1]};
        lo_nxt = lo_nxt << 1;
        if (sh >= {1'b0, src_d}) begin
          sh    = sh - {1'b0, src_d};
          q_nxt = {q_nxt[QD_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QD_W-2:0], 1'b0};
        end
        rem_nxt = sh[D_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]    <= q_nxt;
        side_r[s] <= src_side;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          lo_r[s]  <= lo_nxt;
          d_r[s]   <= src_d;
        end
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_t     = Q1_W'(q_r[DIV_STAGES-1]);
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/soft_clip_audio_mixer.sv
// ----------------------------------------------------------------------------
// soft_clip_audio_mixer
// Sums the active source samples and soft-clips the result with a
// fixed-point tanh curve, sign restored, frame-end flag carried along.
//
//   channel   dir   handshake             payload
//   in_       in    in_valid / in_ready   scmix_in_t  (samples, mask, frame_end)
//   out_      out   out_valid / out_ready scmix_out_t (mixed_sample, frame_end_out)
//
// One transaction per clock while the output is not stalled. Pipeline stages:
// mask-and-add stage, 20-term e^-x series at two multiplier stages per term
// plus a clamp, eight e^-1 multiply stages, a 16-stage divider at two
// quotient bits per stage, and the output register.
// rst_n is synchronous and clears only the valid bits.
// A result arriving at a stalled output fills the skid register; the whole
// pipeline then holds and in_ready drops until the skid register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_clip_audio_mixer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scmix_pkg::scmix_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scmix_pkg::scmix_out_t out_data
);
  import scmix_pkg::*;

  localparam int M_PROD_W = Q1_W + FS_LOG2 + 1;

  logic                       en;
  logic signed [SAMPLE_W-1:0] smp [NUM_SOURCES];
  logic signed [SUM_W-1:0]    sum_nxt;

  logic                       s1_v_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       fe_r;

  logic                       sum_neg;
  logic [MAG_W-1:0]           mag_a;
  logic [Y_W-1:0]             y;
  logic [NFULL_W-1:0]         n_full;
  scmix_side_t                front_side;

  logic                       exp_v;
  logic [Q1_W-1:0]            exp_e;
  scmix_side_t                exp_side;
  logic                       pow_v;
  logic [Q1_W-1:0]            pow_u;
  scmix_side_t                pow_side;
  logic                       div_v;
  logic [Q1_W-1:0]            div_t;
  scmix_side_t                div_side;

  logic [M_PROD_W-1:0]        m_prod;
  logic [M_PROD_W-1:0]        m_full;
  logic [OUT_MAG_W-1:0]       mag_out;
  logic [SAMPLE_W-1:0]        mix_abs;
  scmix_out_t                 mix_nxt;

  logic                       out_v_r;
  scmix_out_t                 out_r;
  logic                       skid_v_r;
  scmix_out_t                 skid_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  assign smp[0] = in_data.sample_a;
  assign smp[1] = in_data.sample_b;
  assign smp[2] = in_data.sample_c;
  assign smp[3] = in_data.sample_d;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (in_data.source_valid[i]) begin
        sum_nxt = sum_nxt + SUM_W'(smp[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      fe_r  <= in_data.frame_end;
    end
  end

  // magnitude, then 2|s|/full_scale in Q30 split into integer and fraction
  assign sum_neg = sum_r[SUM_W-1];
  assign mag_a   = sum_neg ? MAG_W'(~sum_r) + MAG_W'(1) : MAG_W'(sum_r);
  assign y       = {mag_a, {(QBITS + 1 - FS_LOG2){1'b0}}};
  assign n_full  = y[Y_W-1:QBITS];

  always_comb begin
    front_side.neg       = sum_neg;
    front_side.sat       = 32'(n_full) >= 32'd32;
    front_side.frame_end = fe_r;
    front_side.n         = n_full[N_W-1:0];
  end

  scmix_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_v_r),
    .in_g      (y[QBITS-1:0]),
    .in_side   (front_side),
    .out_valid (exp_v),
    .out_e     (exp_e),
    .out_side  (exp_side)
  );

  scmix_pow u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (exp_v),
    .in_u      (exp_e),
    .in_side   (exp_side),
    .out_valid (pow_v),
    .out_u     (pow_u),
    .out_side  (pow_side)
  );

  scmix_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pow_v),
    .in_u      (pow_u),
    .in_side   (pow_side),
    .out_valid (div_v),
    .out_t     (div_t),
    .out_side  (div_side)
  );

  // scale to full scale, saturate, restore sign
  assign m_prod = M_PROD_W'(div_t) * M_PROD_W'(FULL_SCALE);
  assign m_full = m_prod >> QBITS;

  always_comb begin
    if (div_side.sat || (m_full > M_PROD_W'(LIMIT))) begin
      mag_out = OUT_MAG_W'(LIMIT);
    end else begin
      mag_out = m_full[OUT_MAG_W-1:0];
    end
    mix_abs = {1'b0, mag_out};
    mix_nxt.mixed_sample  = div_side.neg ? $signed(-mix_abs) : $signed(mix_abs);
    mix_nxt.frame_end_out = div_side.frame_end;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (div_v) begin
      if (!out_v_r || out_ready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (div_v) begin
      if (!out_v_r || out_ready) begin
        out_r <= mix_nxt;
      end else begin
        skid_r <= mix_nxt;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/scmix_checker.sv
// ----------------------------------------------------------------------------
// scmix_checker
// Port-level checks on the soft-clip mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scmix_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input scmix_pkg::scmix_out_t out_data
);
  import scmix_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending output");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready dropped without an output stall");

  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mixed_sample != {1'b1, {(SAMPLE_W - 1){1'b0}}})
    else $error("mixed sample outside symmetric range");

endmodule

bind soft_clip_audio_mixer scmix_checker u_scmix_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/mix_checker.sv
// ----------------------------------------------------------------------------
// mix_checker
// Watches both channels of the soft-clip mixer. For every accepted input
// transaction it computes the clipped mix of the active sources and queues it.
// Each accepted output transaction is compared field by field with the oldest
// entry in that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mix_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  scmix_pkg::scmix_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  scmix_pkg::scmix_out_t out_data,
  output int                    fail_count,
  output int                    outstanding,
  output int                    checked_count,
  output int                    negative_count
);
  import scmix_pkg::*;

  localparam int          FRAC     = 30;
  localparam logic [63:0] Q_ONE    = 64'd1 << FRAC;
  localparam int          CLIP_MAX = (FULL_SCALE - 1 > 32767) ? 32767 : FULL_SCALE - 1;

  scmix_out_t expected_mix_q[$];

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    checked_count  = 0;
    negative_count = 0;
  end

  // e^-g in Q30 by a 20-term alternating series, clamped to 0..1
  function automatic logic [63:0] neg_exp_series(input logic [63:0] g);
    longint      acc;
    logic [63:0] term;
    int          k;
    acc  = longint'(Q_ONE);
    term = Q_ONE;
    for (k = 1; k <= 20; k++) begin
      term = ((term * g) >> FRAC) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(Q_ONE)) begin
      acc = longint'(Q_ONE);
    end
    return 64'(acc);
  endfunction

  function automatic int tanh_magnitude(input int unsigned mag);
    logic [63:0] y;
    logic [63:0] frac_part;
    logic [63:0] decay;
    logic [63:0] e_one;
    logic [63:0] th;
    logic [63:0] scaled;
    int          whole;
    if (mag == 0) begin
      return 0;
    end
    y = ((64'(mag) * 64'd2) << FRAC) / 64'(FULL_SCALE);
    if (y >= (64'd32 << FRAC)) begin
      return CLIP_MAX;
    end
    whole     = int'(y >> FRAC);
    frac_part = y & (Q_ONE - 64'd1);
    decay     = neg_exp_series(frac_part);
    e_one     = neg_exp_series(Q_ONE);
    for (int i = 0; i < whole; i++) begin
      decay = (decay * e_one) >> FRAC;
    end
    th     = ((Q_ONE - decay) << FRAC) / (Q_ONE + decay);
    scaled = (th * 64'(FULL_SCALE)) >> FRAC;
    if (scaled > 64'(CLIP_MAX)) begin
      scaled = 64'(CLIP_MAX);
    end
    return int'(scaled);
  endfunction

  function automatic scmix_out_t mix_and_clip(input scmix_in_t d);
    scmix_out_t  r;
    int          total;
    int          mag;
    int          src [4];
    src[0] = int'($signed(d.sample_a));
    src[1] = int'($signed(d.sample_b));
    src[2] = int'($signed(d.sample_c));
    src[3] = int'($signed(d.sample_d));
    total  = 0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (d.source_valid[i]) begin
        total = total + src[i];
      end
    end
    mag = tanh_magnitude((total < 0) ? -total : total);
    r.mixed_sample  = (total < 0) ? 16'(-mag) : 16'(mag);
    r.frame_end_out = d.frame_end;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    scmix_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_mix_q.push_back(mix_and_clip(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_mix_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, mixed_sample %0d",
                                    $signed(out_data.mixed_sample)));
        end else begin
          want = expected_mix_q.pop_front();
          if (out_data.mixed_sample !== want.mixed_sample) begin
            report_mismatch($sformatf("mixed_sample got %0d want %0d",
                                      $signed(out_data.mixed_sample),
                                      $signed(want.mixed_sample)));
          end
          if (out_data.frame_end_out !== want.frame_end_out) begin
            report_mismatch($sformatf("frame_end_out got %b want %b",
                                      out_data.frame_end_out, want.frame_end_out));
          end
          if (want.mixed_sample[15]) begin
            negative_count++;
          end
          checked_count++;
        end
      end
    end
    outstanding <= expected_mix_q.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the soft-clip mixer: directed corner transactions,
// then random mixes in four flow-control phases (none, sender idle, receiver
// stall, both). Checking is done by mix_checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import scmix_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 133;
  localparam int TAIL_CYCLES    = 100;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  scmix_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  scmix_out_t out_data;

  int fail_count;
  int outstanding;
  int checked_count;
  int negative_count;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int sent_count    = 0;
  int stall_run     = 0;

  always #10 clk = ~clk;

  soft_clip_audio_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mix_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count),
    .negative_count (negative_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_run <= 0;
      end else if (stall_run >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", stall_run);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_run <= stall_run + 1;
      end
    end
  end

  function automatic scmix_in_t make_mix(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d,
                                         input logic [3:0] mask, input logic fe);
    scmix_in_t t;
    t.sample_a     = a;
    t.sample_b     = b;
    t.sample_c     = c;
    t.sample_d     = d;
    t.source_valid = mask;
    t.frame_end    = fe;
    return t;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] s;
    case ($urandom_range(7))
      0, 1: s = 16'($signed($urandom_range(64)) - 32);
      2: begin
        case ($urandom_range(3))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          2: s = 16'hFFFF;
          default: s = 16'h0000;
        endcase
      end
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic send_mix(input scmix_in_t t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_mix(make_mix(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                        4'($urandom_range(15)), ($urandom_range(3) == 0)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, no idling
    send_mix(make_mix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF, 1'b0));
    send_mix(make_mix(16'h7FFF, 16'h8000, 16'h1234, 16'hABCD, 4'h0, 1'b1));
    send_mix(make_mix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 1'b0));
    send_mix(make_mix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, 1'b1));
    send_mix(make_mix(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b0));
    send_mix(make_mix(16'h0000, 16'h8000, 16'h0000, 16'h0000, 4'h2, 1'b0));
    send_mix(make_mix(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 4'h4, 1'b1));
    send_mix(make_mix(16'h0000, 16'h0000, 16'h0000, 16'h8000, 4'h8, 1'b0));
    send_mix(make_mix(16'd5, 16'hFFFB, 16'h0000, 16'h0000, 4'h3, 1'b0));
    send_mix(make_mix(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 4'hF, 1'b0));
    send_mix(make_mix(16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b0));
    send_mix(make_mix(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b1));
    send_mix(make_mix(16'h4000, 16'h4000, 16'h0000, 16'h0000, 4'h3, 1'b0));
    send_mix(make_mix(16'hC000, 16'hC000, 16'hC000, 16'h0000, 4'h7, 1'b0));
    send_mix(make_mix(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 4'h5, 1'b1));
    send_mix(make_mix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'hA, 1'b0));
    wait_drained();

    random_phase(0, 0);
    random_phase(61, 0);
    random_phase(0, 61);
    random_phase(25, 25);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d transactions (directed corners plus random mixes) over four",
             sent_count);
    $display("flow-control phases; %0d results checked, %0d of them negative",
             checked_count, negative_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
